### rtl/dke_pkg.sv
// shared types, constants and character translation for the debounced key encoder
// used by every module of the block; depends on nothing else
`default_nettype none

package dke_pkg;

   // scan and keymap geometry
   localparam int SWITCH_COUNT_DEFAULT = 16;
   localparam int SCAN_BITS            = 16;
   localparam int SWITCH_IDX_W         = 4;
   localparam int MAP_DEPTH            = 16;
   localparam int MAP_IDX_W            = 4;
   localparam int MAP_BYTE_W           = 8;
   localparam int CHAR_W               = 7;

   // stream payload widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   // item kinds
   typedef enum logic {
      OP_SCAN  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // characters touched by the shift translation
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_2       = 8'h32;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_4       = 8'h34;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_6       = 8'h36;
   localparam logic [7:0] CH_7       = 8'h37;
   localparam logic [7:0] CH_8       = 8'h38;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_QUEST   = 8'h3F;

   // decoded scan pair
   typedef struct packed {
      logic                    hit;
      logic [SWITCH_IDX_W-1:0] index;
      logic                    shift;
   } scan_pair_type;

   // highest set bit of a scan vector
   typedef struct packed {
      logic                    any;
      logic [SWITCH_IDX_W-1:0] index;
   } find_type;

   function automatic find_type find_high(input logic [SCAN_BITS-1:0] vec);
      find_type r;
      r.any   = 1'b0;
      r.index = '0;
      for (int i = 0; i < SCAN_BITS; i++) begin
         if (vec[i]) begin
            r.any   = 1'b1;
            r.index = SWITCH_IDX_W'(i);
         end
      end
      return r;
   endfunction

   // shifted form of a character, others unchanged
   function automatic logic [CHAR_W-1:0] shift_char(input logic [7:0] c);
      logic [7:0] r;
      case (c) inside
         [CH_LOWER_A:CH_LOWER_Z]: r = c - CASE_DELTA;
         CH_0:     r = CH_RPAREN;
         CH_2:     r = CH_DQUOTE;
         CH_3:     r = CH_HASH;
         CH_4:     r = CH_DOLLAR;
         CH_5:     r = CH_PERCENT;
         CH_6:     r = CH_UNDER;
         CH_7:     r = CH_AMP;
         CH_8:     r = CH_QUOTE;
         CH_9:     r = CH_LPAREN;
         CH_SEMI:  r = CH_COLON;
         CH_SLASH: r = CH_QUEST;
         default:  r = c;
      endcase
      return r[CHAR_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/dke_scan_decode.sv
// priority decode of a scan pair: agreed key switch and shift state
// depends on dke_pkg
`default_nettype none

module dke_scan_decode #(
   parameter int SWITCH_COUNT = dke_pkg::SWITCH_COUNT_DEFAULT
) (
   input  wire logic [dke_pkg::SCAN_BITS-1:0]    first_scan,
   input  wire logic [dke_pkg::SCAN_BITS-1:0]    second_scan,
   input  wire logic [dke_pkg::SWITCH_IDX_W-1:0] shift_idx,
   output dke_pkg::scan_pair_type                pair
);

   localparam int SCAN_LIMIT =
      (SWITCH_COUNT < dke_pkg::SCAN_BITS) ? SWITCH_COUNT : dke_pkg::SCAN_BITS;

   logic [dke_pkg::SCAN_BITS-1:0] scan_mask;
   logic [dke_pkg::SCAN_BITS-1:0] shift_bit;
   logic [dke_pkg::SCAN_BITS-1:0] pressed_a;
   logic [dke_pkg::SCAN_BITS-1:0] pressed_b;
   dke_pkg::find_type             find_a;
   dke_pkg::find_type             find_b;

   // only scanned positions count, switches are active low
   always_comb begin
      for (int i = 0; i < dke_pkg::SCAN_BITS; i++) begin
         scan_mask[i] = (i < SCAN_LIMIT);
      end
      shift_bit = dke_pkg::SCAN_BITS'(1) << shift_idx;
      pressed_a = ~first_scan & scan_mask;
      pressed_b = ~second_scan & scan_mask;
   end

   // highest pressed non-shift switch in each scan
   always_comb begin
      find_a = dke_pkg::find_high(pressed_a & ~shift_bit);
      find_b = dke_pkg::find_high(pressed_b & ~shift_bit);
   end

   // both scans must agree, shift comes from the second scan
   always_comb begin
      pair.hit   = find_a.any && find_b.any && (find_a.index == find_b.index);
      pair.index = find_a.index;
      pair.shift = |(pressed_b & shift_bit);
   end

endmodule

`default_nettype wire

### rtl/dke_keymap.sv
// keymap storage: one byte per switch position, write port and one read port
// depends on dke_pkg
`default_nettype none

module dke_keymap (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [dke_pkg::MAP_IDX_W-1:0]    wr_index,
   input  wire logic [dke_pkg::MAP_BYTE_W-1:0]   wr_data,
   input  wire logic [dke_pkg::MAP_IDX_W-1:0]    rd_index,
   output logic      [dke_pkg::MAP_BYTE_W-1:0]   rd_data
);

   logic [dke_pkg::MAP_BYTE_W-1:0] map_ff [dke_pkg::MAP_DEPTH];

   // entries hold nothing defined until written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_index] <= wr_data;
      end
   end

   // read mux
   assign rd_data = map_ff[rd_index];

endmodule

`default_nettype wire

### rtl/debounced_key_encoder_core.sv
// an accepted item is held in the input register; an emitted character then moves into the result register
// throughput: one item per cycle; the single input register and the result
//   register part the two sides, so a held result stalls input only on a key change
// reset: synchronous active-high reset empties both registers, clears the last
//   character and the shift index; keymap entries are not cleared
// top level of the debounced key encoder; depends on dke_pkg, dke_scan_decode, dke_keymap
`default_nettype none

module debounced_key_encoder_core #(
   parameter int SWITCH_COUNT = dke_pkg::SWITCH_COUNT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request item
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // opcode
   input  wire logic                                req_tuser,
   // first_scan[15:0], second_scan[31:16], map_index[35:32], map_char[43:36]
   input  wire logic [dke_pkg::REQ_DATA_W-1:0]      req_tdata,
   // result item
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // key_char[6:0]
   output logic      [dke_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // shift switch index register
   input  wire logic                                csr_wr_en,
   input  wire logic [dke_pkg::SWITCH_IDX_W-1:0]    csr_wr_data
);

   // input register
   logic                                  s1_valid_ff, s1_valid_in;
   dke_pkg::op_type                       s1_op_ff;
   logic [dke_pkg::SCAN_BITS-1:0]         s1_first_ff, s1_second_ff;
   logic [dke_pkg::MAP_IDX_W-1:0]         s1_map_idx_ff;
   logic [dke_pkg::MAP_BYTE_W-1:0]        s1_map_char_ff;

   // block state
   logic [dke_pkg::SWITCH_IDX_W-1:0]      shift_idx_ff;
   logic [dke_pkg::CHAR_W-1:0]            last_char_ff, last_char_in;
   logic                                  last_valid_ff, last_valid_in;

   // result register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [dke_pkg::CHAR_W-1:0]            rsp_char_ff;

   dke_pkg::scan_pair_type                pair;
   logic [dke_pkg::MAP_BYTE_W-1:0]        map_byte;
   logic [dke_pkg::CHAR_W-1:0]            key_ch;
   logic                                  key_ok;
   logic                                  is_scan;
   logic                                  emit;
   logic                                  out_free;
   logic                                  s1_consume;
   logic                                  accept;

   dke_scan_decode #(
      .SWITCH_COUNT (SWITCH_COUNT)
   ) u_decode (
      .first_scan  (s1_first_ff),
      .second_scan (s1_second_ff),
      .shift_idx   (shift_idx_ff),
      .pair        (pair)
   );

   dke_keymap u_keymap (
      .clock    (clock),
      .wr_en    (s1_consume && (s1_op_ff == dke_pkg::OP_WRITE)),
      .wr_index (s1_map_idx_ff),
      .wr_data  (s1_map_char_ff),
      .rd_index (pair.index[dke_pkg::MAP_IDX_W-1:0]),
      .rd_data  (map_byte)
   );

   // character lookup and change detection
   always_comb begin
      is_scan = (s1_op_ff == dke_pkg::OP_SCAN);
      key_ok  = pair.hit && !map_byte[dke_pkg::MAP_BYTE_W-1];
      key_ch  = pair.shift ? dke_pkg::shift_char(map_byte) : map_byte[dke_pkg::CHAR_W-1:0];
      emit    = is_scan && key_ok && (!last_valid_ff || (key_ch != last_char_ff));
   end

   // handshake: an item leaves the input register unless its result is blocked
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      s1_consume  = s1_valid_ff && (!emit || out_free);
      req_tready  = !s1_valid_ff || s1_consume;
      accept      = req_tvalid && req_tready;
      s1_valid_in = accept ? 1'b1 : (s1_consume ? 1'b0 : s1_valid_ff);
   end

   // last key tracking, scan items only
   always_comb begin
      last_char_in  = last_char_ff;
      last_valid_in = last_valid_ff;
      if (s1_consume && is_scan) begin
         last_char_in  = key_ok ? key_ch : '0;
         last_valid_in = key_ok;
      end
   end

   // result register
   always_comb begin
      if (s1_consume && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_char_ff  <= '0;
         last_valid_ff <= 1'b0;
         shift_idx_ff  <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_char_ff  <= last_char_in;
         last_valid_ff <= last_valid_in;
         if (csr_wr_en) begin
            shift_idx_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= dke_pkg::op_type'(req_tuser);
         s1_first_ff    <= req_tdata[15:0];
         s1_second_ff   <= req_tdata[31:16];
         s1_map_idx_ff  <= req_tdata[35:32];
         s1_map_char_ff <= req_tdata[43:36];
      end
      if (s1_consume && emit) begin
         rsp_char_ff <= key_ch;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};

   // input stalls only while the input register holds an item
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   // a keymap write leaves the last key untouched
   a_write_keeps_last: assert property (@(posedge clock) disable iff (reset)
      (s1_consume && (s1_op_ff == dke_pkg::OP_WRITE)) |=>
         ($stable(last_valid_ff) && $stable(last_char_ff)))
      else $error("keymap write changed last key");

   // no key means a cleared character
   a_no_key_zero: assert property (@(posedge clock) disable iff (reset)
      !last_valid_ff |-> (last_char_ff == '0))
      else $error("last character set without a key");

   // an emitted item shows up as a valid result and becomes the last key
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (s1_consume && emit) |=> (rsp_valid_ff && last_valid_ff && (rsp_char_ff == last_char_ff)))
      else $error("emitted key not loaded");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for debounced_key_encoder_core: directed rows, then random
// phases under varying idle and stall patterns; depends on dke_pkg and the core rtl

module tb_top;

   localparam int SWITCHES      = dke_pkg::SWITCH_COUNT_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 88;
   localparam int PHASES        = 6;

   typedef struct {
      dke_pkg::op_type                op;
      logic [dke_pkg::SCAN_BITS-1:0]  scan_a;
      logic [dke_pkg::SCAN_BITS-1:0]  scan_b;
      logic [dke_pkg::MAP_IDX_W-1:0]  slot;
      logic [dke_pkg::MAP_BYTE_W-1:0] code;
   } key_item_type;

   typedef struct {
      key_item_type               item;
      logic                       typed;
      logic                       emits;
      logic [dke_pkg::CHAR_W-1:0] want;
   } dir_row_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic                             req_tuser   = 1'b0;
   logic [dke_pkg::REQ_DATA_W-1:0]   req_tdata   = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [dke_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_wr_en   = 1'b0;
   logic [dke_pkg::SWITCH_IDX_W-1:0] csr_wr_data = '0;

   // shadow state of the encoder
   logic [dke_pkg::MAP_BYTE_W-1:0]   keymap_copy [dke_pkg::MAP_DEPTH];
   logic [dke_pkg::MAP_DEPTH-1:0]    slot_written = '0;
   logic [dke_pkg::CHAR_W-1:0]       prev_char    = '0;
   logic                             prev_valid   = 1'b0;
   logic [dke_pkg::SWITCH_IDX_W-1:0] shift_slot   = '0;

   logic [dke_pkg::CHAR_W-1:0] pending_chars [$];
   logic [dke_pkg::CHAR_W-1:0] due_char;
   key_item_type               last_scan;
   logic                       have_last_scan = 1'b0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int mismatches  = 0;
   int items_sent  = 0;
   int map_writes  = 0;
   int chars_seen  = 0;

   debounced_key_encoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // highest pressed switch other than shift, -1 when none
   function automatic int top_switch(input logic [dke_pkg::SCAN_BITS-1:0] scan,
                                     output logic shift_held);
      int hit;
      hit = -1;
      shift_held = 1'b0;
      for (int p = 0; p < SWITCHES && p < dke_pkg::SCAN_BITS; p++) begin
         if (!scan[p]) begin
            if (p == int'(shift_slot)) shift_held = 1'b1;
            else hit = p;
         end
      end
      return hit;
   endfunction

   function automatic logic [7:0] shifted_char(input logic [7:0] c);
      if (c >= dke_pkg::CH_LOWER_A && c <= dke_pkg::CH_LOWER_Z)
         return c - dke_pkg::CASE_DELTA;
      case (c)
         dke_pkg::CH_0:     return dke_pkg::CH_RPAREN;
         dke_pkg::CH_2:     return dke_pkg::CH_DQUOTE;
         dke_pkg::CH_3:     return dke_pkg::CH_HASH;
         dke_pkg::CH_4:     return dke_pkg::CH_DOLLAR;
         dke_pkg::CH_5:     return dke_pkg::CH_PERCENT;
         dke_pkg::CH_6:     return dke_pkg::CH_UNDER;
         dke_pkg::CH_7:     return dke_pkg::CH_AMP;
         dke_pkg::CH_8:     return dke_pkg::CH_QUOTE;
         dke_pkg::CH_9:     return dke_pkg::CH_LPAREN;
         dke_pkg::CH_SEMI:  return dke_pkg::CH_COLON;
         dke_pkg::CH_SLASH: return dke_pkg::CH_QUEST;
         default:           return c;
      endcase
   endfunction

   // advance the shadow state by one item; returns 1 when a new char is due
   function automatic logic predict_char(input key_item_type it,
                                         output logic [dke_pkg::CHAR_W-1:0] ch);
      logic       sh_a;
      logic       sh_b;
      logic       hit;
      logic [7:0] m;
      logic [7:0] t;
      int         a;
      int         b;
      ch  = '0;
      hit = 1'b0;
      if (it.op == dke_pkg::OP_WRITE) begin
         keymap_copy[it.slot]  = it.code;
         slot_written[it.slot] = 1'b1;
         return 1'b0;
      end
      a = top_switch(it.scan_a, sh_a);
      b = top_switch(it.scan_b, sh_b);
      if (a >= 0 && a == b) begin
         m = keymap_copy[a];
         if (!m[7]) begin
            t   = sh_b ? shifted_char(m) : m;
            ch  = t[dke_pkg::CHAR_W-1:0];
            hit = 1'b1;
         end
      end
      if (hit && (!prev_valid || ch != prev_char)) begin
         prev_char  = ch;
         prev_valid = 1'b1;
         return 1'b1;
      end
      prev_char  = hit ? ch : '0;
      prev_valid = hit;
      return 1'b0;
   endfunction

   // scan with one key held, optional shift and optional lower-numbered bounce
   function automatic logic [dke_pkg::SCAN_BITS-1:0] key_scan(input int key,
                                                               input logic with_shift);
      logic [dke_pkg::SCAN_BITS-1:0] pressed;
      pressed = dke_pkg::SCAN_BITS'(1) << key;
      if ($urandom_range(99) < 30)
         pressed |= dke_pkg::SCAN_BITS'($urandom()) &
                    ((dke_pkg::SCAN_BITS'(1) << key) - 1'b1);
      if (with_shift) pressed[shift_slot] = 1'b1;
      return ~pressed;
   endfunction

   // keymap bytes weighted toward characters that shift translates
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 40) return dke_pkg::CH_LOWER_A + 8'($urandom_range(25));
      if (r < 60) return dke_pkg::CH_0 + 8'($urandom_range(9));
      if (r < 70) return ($urandom_range(1) != 0) ? dke_pkg::CH_SEMI : dke_pkg::CH_SLASH;
      if (r < 85) return 8'($urandom_range(127));
      return 8'($urandom());
   endfunction

   function automatic key_item_type next_random_item();
      key_item_type it;
      int           r;
      int           key;
      int           a;
      int           b;
      logic         sh;
      r         = $urandom_range(99);
      it.op     = dke_pkg::OP_SCAN;
      it.scan_a = dke_pkg::SCAN_BITS'($urandom());
      it.scan_b = dke_pkg::SCAN_BITS'($urandom());
      it.slot   = dke_pkg::MAP_IDX_W'($urandom());
      it.code   = 8'($urandom());
      if (r < 12) begin
         it.op   = dke_pkg::OP_WRITE;
         it.code = pick_byte();
      end else if (r < 30 && have_last_scan) begin
         it = last_scan;
      end else if (r < 75) begin
         // well-formed press, sometimes bouncing to another key on the second scan
         key       = int'($urandom_range(SWITCHES - 1));
         sh        = 1'($urandom_range(1));
         it.scan_a = key_scan(key, sh);
         if ($urandom_range(99) < 30) sh = !sh;
         if ($urandom_range(99) < 12) key = int'($urandom_range(SWITCHES - 1));
         it.scan_b = key_scan(key, sh);
      end else if (r < 88) begin
         it.scan_b = it.scan_a;
      end else if (r < 94) begin
         it.scan_a = '1;
      end
      // never look up an entry that has not been written yet
      if (it.op == dke_pkg::OP_SCAN) begin
         a = top_switch(it.scan_a, sh);
         b = top_switch(it.scan_b, sh);
         if (a >= 0 && a == b && !slot_written[a]) begin
            it.op   = dke_pkg::OP_WRITE;
            it.slot = dke_pkg::MAP_IDX_W'(a);
            it.code = pick_byte();
         end
      end
      return it;
   endfunction

   function automatic dir_row_type map_row(input logic [dke_pkg::MAP_IDX_W-1:0] slot,
                                           input logic [dke_pkg::MAP_BYTE_W-1:0] code);
      dir_row_type row;
      row.item.op     = dke_pkg::OP_WRITE;
      row.item.scan_a = '0;
      row.item.scan_b = '0;
      row.item.slot   = slot;
      row.item.code   = code;
      row.typed       = 1'b1;
      row.emits       = 1'b0;
      row.want        = '0;
      return row;
   endfunction

   function automatic dir_row_type scan_row(input logic [dke_pkg::SCAN_BITS-1:0] a,
                                            input logic [dke_pkg::SCAN_BITS-1:0] b,
                                            input logic typed, input logic emits,
                                            input logic [7:0] want);
      dir_row_type row;
      row.item.op     = dke_pkg::OP_SCAN;
      row.item.scan_a = a;
      row.item.scan_b = b;
      row.item.slot   = '0;
      row.item.code   = '0;
      row.typed       = typed;
      row.emits       = emits;
      row.want        = want[dke_pkg::CHAR_W-1:0];
      return row;
   endfunction

   // offer one item, wait for acceptance, then record what it should produce
   task automatic send_item(input key_item_type it, input logic typed, input logic emits,
                            input logic [dke_pkg::CHAR_W-1:0] want);
      logic [dke_pkg::CHAR_W-1:0] ch;
      logic                       due;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= dke_pkg::REQ_DATA_W'({it.code, it.slot, it.scan_b, it.scan_a});
      do @(posedge clock); while (!req_tready);
      due = predict_char(it, ch);
      if (typed) begin
         due = emits;
         ch  = want;
      end
      if (due) pending_chars.push_back(ch);
      items_sent++;
      if (it.op == dke_pkg::OP_WRITE) map_writes++;
   endtask

   // let the block go idle, then program the shift switch
   task automatic set_shift_slot(input logic [dke_pkg::SWITCH_IDX_W-1:0] slot);
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= slot;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shift_slot   = slot;
   endtask

   // result side stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // compare each accepted char with the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_seen++;
         if (pending_chars.size() == 0) begin
            $display("%0t: key_char expected none, actual 0x%02h",
                     $time, rsp_tdata[dke_pkg::CHAR_W-1:0]);
            mismatches++;
         end else begin
            due_char = pending_chars.pop_front();
            if (rsp_tdata[dke_pkg::CHAR_W-1:0] !== due_char) begin
               $display("%0t: key_char expected 0x%02h, actual 0x%02h",
                        $time, due_char, rsp_tdata[dke_pkg::CHAR_W-1:0]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      dir_row_type                      rows [$];
      key_item_type                     it;
      logic [dke_pkg::SWITCH_IDX_W-1:0] shift_plan [PHASES] =
         '{4'd15, 4'd6, 4'd0, 4'd9, 4'd15, 4'd1};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 31;
      rx_idle_pct = 79;
      set_shift_slot(4'd0);

      // directed rows, shift on switch 0
      rows.push_back(map_row(4'd15, dke_pkg::CH_LOWER_A));
      rows.push_back(map_row(4'd1, dke_pkg::CH_3));
      rows.push_back(map_row(4'd7, 8'h80));
      rows.push_back(map_row(4'd4, dke_pkg::CH_SEMI));
      rows.push_back(map_row(4'd2, 8'h7F));
      rows.push_back(map_row(4'd3, 8'h00));
      // char zero right after reset still counts as new
      rows.push_back(scan_row(16'hFFF7, 16'hFFF7, 1'b1, 1'b1, 8'h00));
      rows.push_back(scan_row(16'hFFF7, 16'hFFF7, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'hFFF7, 16'hFFF7, 1'b1, 1'b1, 8'h00));
      rows.push_back(scan_row(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, dke_pkg::CH_LOWER_A));
      // shift counts from the second scan only
      rows.push_back(scan_row(16'h7FFF, 16'h7FFE, 1'b1, 1'b1, 8'h41));
      rows.push_back(scan_row(16'h7FFE, 16'h7FFF, 1'b1, 1'b1, dke_pkg::CH_LOWER_A));
      // only shift in the first scan means no key
      rows.push_back(scan_row(16'hFFFE, 16'h7FFF, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'hFFFC, 16'hFFFC, 1'b1, 1'b1, dke_pkg::CH_HASH));
      rows.push_back(scan_row(16'hFFFD, 16'h7FFF, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'hFF7F, 16'hFF7F, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'hFFEE, 16'hFFEE, 1'b1, 1'b1, dke_pkg::CH_COLON));
      rows.push_back(scan_row(16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00));
      rows.push_back(scan_row(16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'hFFFA, 16'hFFFA, 1'b1, 1'b1, 8'h7F));
      // a keymap write leaves the last char alone
      rows.push_back(map_row(4'd0, dke_pkg::CH_SLASH));
      rows.push_back(scan_row(16'hFFFA, 16'hFFFA, 1'b1, 1'b0, 8'h00));
      rows.push_back(scan_row(16'h7FFB, 16'h7FEF, 1'b0, 1'b0, 8'h00));
      foreach (rows[i])
         send_item(rows[i].item, rows[i].typed, rows[i].emits, rows[i].want);

      // random phases: receiver-heavy stalls, sender-heavy idling, then full rate
      for (int ph = 0; ph < PHASES; ph++) begin
         tx_idle_pct = (ph / 2 == 0) ? 31 : (ph / 2 == 1) ? 79 : 0;
         rx_idle_pct = (ph / 2 == 0) ? 79 : (ph / 2 == 1) ? 31 : 0;
         set_shift_slot(shift_plan[ph]);
         repeat (PHASE_ITEMS) begin
            it = next_random_item();
            if (it.op == dke_pkg::OP_SCAN) begin
               last_scan      = it;
               have_last_scan = 1'b1;
            end
            send_item(it, 1'b0, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      for (int n = 0; n < 20000 && pending_chars.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $display("%0t: %0d key_char results never arrived", $time, pending_chars.size());
         mismatches++;
      end
      $display("run: %0d items sent, %0d of them keymap writes, %0d chars received",
               items_sent, map_writes, chars_seen);
      $display("run: %0d shift switch settings, %0d mismatches", PHASES + 1, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("%0t: watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/dke_pkg.sv
rtl/dke_scan_decode.sv
rtl/dke_keymap.sv
rtl/debounced_key_encoder_core.sv
sim/tb_top.sv
